>>> rtl/core/mera_pkg.sv
// Shared types and constants for the multi-turn encoder rate average block.
// No dependencies; imported by every module under rtl/core.
package mera_pkg;

  localparam int POS_W   = 13;  // single-turn encoder counts
  localparam int INC_W   = 14;  // wrap-corrected increment
  localparam int SPEED_W = 16;
  localparam int CONT_W  = 37;  // continuous position / angle
  localparam int RATE_W  = 14;  // window mean
  localparam int CAL_W   = 4;

  localparam logic [CAL_W-1:0] CAL_RESET = 4'd5;

  // increment arithmetic runs one bit wider than the increment itself
  localparam logic signed [INC_W:0] HALF_TURN_POS = 15'sd4096;
  localparam logic signed [INC_W:0] HALF_TURN_NEG = -15'sd4096;
  localparam logic signed [INC_W:0] FULL_TURN     = 15'sd8192;

  typedef logic        [POS_W-1:0]   pos_t;
  typedef logic signed [INC_W-1:0]   inc_t;
  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [CONT_W-1:0]  cont_t;
  typedef logic signed [RATE_W-1:0]  rate_t;
  typedef logic        [CAL_W-1:0]   cal_cnt_t;

  // load strobes for the two register stages of the mean unit
  typedef struct packed {
    logic ld_prod;
    logic ld_out;
  } mean_ctl_t;

endpackage

>>> rtl/core/mera_cell.sv
// One cell of the increment window: holds one increment, passes it on.
// Depends on mera_pkg.
module mera_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  mera_pkg::inc_t d_i,
  output mera_pkg::inc_t q_o
);
  import mera_pkg::*;

  inc_t val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d_i;
    end
  end

  assign q_o = val_r;

endmodule

>>> rtl/core/mera_mean.sv
// Window mean: signed sum divided by WINDOW_LEN, truncated toward zero.
// Reciprocal multiply on the magnitude, two registered steps. Depends on mera_pkg.
module mera_mean #(
  parameter int WINDOW_LEN = 8,
  parameter int SUM_W      = 18
) (
  input  logic                    clk,
  input  mera_pkg::mean_ctl_t     ctl,
  input  logic signed [SUM_W-1:0] sum_i,
  output mera_pkg::rate_t         mean_o
);
  import mera_pkg::*;

  // exact floor(a / WINDOW_LEN) for every a < 2**SUM_W
  localparam int K = SUM_W + $clog2(WINDOW_LEN) + 1;
  localparam int PROD_W = SUM_W + K + 1;
  localparam logic [K:0] RECIP = (K+1)'(((1 << K) + WINDOW_LEN - 1) / WINDOW_LEN);

  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic              neg_r;
  rate_t             quot;
  rate_t             mean_r;
  rate_t             mean_nxt;

  always_comb begin
    mag      = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    prod_nxt = PROD_W'(mag) * PROD_W'(RECIP);
    quot     = prod_r[K +: RATE_W];
    mean_nxt = neg_r ? -quot : quot;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_r <= prod_nxt;
      neg_r  <= sum_i[SUM_W-1];
    end
    if (ctl.ld_out) begin
      mean_r <= mean_nxt;
    end
  end

  assign mean_o = mean_r;

endmodule

>>> rtl/core/multiturn_encoder_rate_average.sv
// Multi-turn encoder unwrap with moving average of position increments.
// Depends on mera_pkg, mera_cell and mera_mean.
//
// Takes one item per clock while in_stall is low (13-bit single-turn position
// plus signed speed) and returns one result item per input item. The result
// passes three register stages (snapshot, position/angle, output) before
// out_valid rises. All state (calibration count, bias, previous position,
// turn count, window of increments and its running sum) is updated in the
// cycle the item is accepted, so items may follow each other every cycle.
// The first cfg calib_reports items (reset value 5) only capture the
// position as bias and previous position and come out with calibrating set.
// After that, a jump of more than half a turn counts a turn up or down
// (saturating at the signed TURN_BITS range); the wrap-corrected increment
// shifts into a chain of WINDOW_LEN cells while the running sum adds the new
// increment and drops the one leaving the last cell. The mean is a reciprocal
// multiply of the sum, truncated toward zero. Write calib_reports only while
// the block is idle. Backpressure on out_stall reaches in_stall
// combinationally through the ready chain of the three stages.
module multiturn_encoder_rate_average #(
  parameter int WINDOW_LEN = 8,
  parameter int TURN_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  mera_pkg::cal_cnt_t  cfg_wr_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  mera_pkg::pos_t      in_encoder_position,
  input  mera_pkg::speed_t    in_speed_report,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output mera_pkg::cont_t     out_continuous_position,
  output mera_pkg::cont_t     out_angle_counts,
  output mera_pkg::rate_t     out_average_rate,
  output mera_pkg::speed_t    out_speed_out,
  output logic                out_calibrating
);
  import mera_pkg::*;

  // sum of WINDOW_LEN increments, with headroom
  localparam int SUM_W  = INC_W + 1 + $clog2(WINDOW_LEN);
  localparam int WIDE_W = TURN_BITS + POS_W;
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

  // ---------------- handshake / pipeline control ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_ready, s2_ready, s1_ready, acc;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r  || out_ready;
  assign s1_ready  = !s1_v_r  || s2_ready;
  assign in_stall  = !s1_ready;
  assign acc       = in_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready)  s1_v_r  <= acc;
      if (s2_ready)  s2_v_r  <= s1_v_r;
      if (out_ready) out_v_r <= s2_v_r;
    end
  end

  assign out_valid = out_v_r;

  // ---------------- tracking state ----------------
  cal_cnt_t                     calib_r;
  cal_cnt_t                     rpt_cnt_r;
  pos_t                         bias_r, prev_r;
  logic signed [TURN_BITS-1:0]  turn_r;
  logic signed [SUM_W-1:0]      sum_r;

  logic                         cal;
  logic signed [INC_W:0]        diff;
  inc_t                         inc;
  logic signed [TURN_BITS-1:0]  turn_nxt;
  logic signed [SUM_W-1:0]      sum_nxt;
  pos_t                         bias_nxt;
  inc_t                         oldest;

  always_comb begin
    cal      = rpt_cnt_r < calib_r;
    diff     = $signed({2'b00, in_encoder_position}) - $signed({2'b00, prev_r});
    turn_nxt = turn_r;
    inc      = INC_W'(diff);
    if (diff < HALF_TURN_NEG) begin
      inc = INC_W'(diff + FULL_TURN);
      if (turn_r != TURN_MAX) turn_nxt = turn_r + 1'b1;
    end else if (diff > HALF_TURN_POS) begin
      inc = INC_W'(diff - FULL_TURN);
      if (turn_r != TURN_MIN) turn_nxt = turn_r - 1'b1;
    end
    sum_nxt  = sum_r + SUM_W'(inc) - SUM_W'(oldest);
    bias_nxt = bias_r;
    if (cal) begin
      turn_nxt = turn_r;
      sum_nxt  = sum_r;
      bias_nxt = in_encoder_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r   <= CAL_RESET;
      rpt_cnt_r <= '0;
      bias_r    <= '0;
      prev_r    <= '0;
      turn_r    <= '0;
      sum_r     <= '0;
    end else begin
      if (cfg_wr_en) calib_r <= cfg_wr_data;
      if (acc) begin
        if (cal) rpt_cnt_r <= rpt_cnt_r + 1'b1;
        bias_r <= bias_nxt;
        prev_r <= in_encoder_position;
        turn_r <= turn_nxt;
        sum_r  <= sum_nxt;
      end
    end
  end

  // ---------------- increment window: chain of cells ----------------
  inc_t cell_q [WINDOW_LEN];
  logic win_shift;

  assign win_shift = acc && !cal;
  assign oldest    = cell_q[WINDOW_LEN-1];

  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
    inc_t d_in;
    if (g == 0) begin : g_head
      assign d_in = inc;
    end else begin : g_link
      assign d_in = cell_q[g-1];
    end
    mera_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (win_shift),
      .d_i      (d_in),
      .q_o      (cell_q[g])
    );
  end

  // ---------------- stage 1: post-update snapshot ----------------
  pos_t                        s1_pos_r, s1_bias_r;
  logic signed [TURN_BITS-1:0] s1_turn_r;
  logic signed [SUM_W-1:0]     s1_sum_r;
  speed_t                      s1_speed_r;
  logic                        s1_cal_r;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_pos_r   <= in_encoder_position;
      s1_bias_r  <= bias_nxt;
      s1_turn_r  <= turn_nxt;
      s1_sum_r   <= sum_nxt;
      s1_speed_r <= in_speed_report;
      s1_cal_r   <= cal;
    end
  end

  // ---------------- stage 2: position and angle ----------------
  logic signed [WIDE_W-1:0] wide_pos;
  cont_t                    cont;
  cont_t                    s2_cont_r, s2_angle_r;
  speed_t                   s2_speed_r;
  logic                     s2_cal_r;

  // turn*8192 + pos is the concatenation, pos being below one turn
  assign wide_pos = {s1_turn_r, s1_pos_r};
  assign cont     = CONT_W'(wide_pos);

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_cont_r  <= cont;
      s2_angle_r <= cont - $signed({{(CONT_W-POS_W){1'b0}}, s1_bias_r});
      s2_speed_r <= s1_speed_r;
      s2_cal_r   <= s1_cal_r;
    end
  end

  // ---------------- window mean (stages 2 and 3) ----------------
  mean_ctl_t mean_ctl;
  assign mean_ctl.ld_prod = s2_ready;
  assign mean_ctl.ld_out  = out_ready;

  mera_mean #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_mean (
    .clk    (clk),
    .ctl    (mean_ctl),
    .sum_i  (s1_sum_r),
    .mean_o (out_average_rate)
  );

  // ---------------- output register ----------------
  cont_t  out_cont_r, out_angle_r;
  speed_t out_speed_r;
  logic   out_cal_r;

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_cont_r  <= s2_cont_r;
      out_angle_r <= s2_angle_r;
      out_speed_r <= s2_speed_r;
      out_cal_r   <= s2_cal_r;
    end
  end

  assign out_continuous_position = out_cont_r;
  assign out_angle_counts        = out_angle_r;
  assign out_speed_out           = out_speed_r;
  assign out_calibrating         = out_cal_r;

endmodule

>>> bench/tb_multiturn_encoder_rate_average.sv
`timescale 1ns / 1ps
// Self-checking bench for multiturn_encoder_rate_average: predicts every result item
// (unwrap, bias, window mean) and compares it field by field with the block.
// Depends on mera_pkg and the block's RTL; reads no files.
module tb_multiturn_encoder_rate_average;
  import mera_pkg::*;

  // Block configuration as instantiated below.
  localparam int WINDOW_LEN = 8;
  localparam int TURN_BITS  = 24;
  localparam longint TURN_MAX = (longint'(1) << (TURN_BITS - 1)) - 1;
  localparam longint TURN_MIN = -TURN_MAX - 1;

  localparam int FULL_COUNTS = 8192;  // encoder counts per turn
  localparam int HALF_COUNTS = 4096;  // a jump of exactly this much is not a wrap

  localparam int DRAIN_CYCLES = 6;       // three pipeline stages plus margin
  localparam int CYCLE_LIMIT  = 200000;  // watchdog bound for the whole run
  localparam int MAX_REPORTED = 10;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_mode_t;

  // One expected result item.
  typedef struct {
    cont_t  cont_pos;
    cont_t  angle;
    rate_t  avg_rate;
    speed_t speed;
    logic   cal;
  } report_result_t;

  // ---------------------------------------------------------------------------
  // DUT connections; every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_wr_en = 1'b0;
  cal_cnt_t cfg_wr_data = '0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pos_t     in_encoder_position = '0;
  speed_t   in_speed_report = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cont_t    out_continuous_position;
  cont_t    out_angle_counts;
  rate_t    out_average_rate;
  speed_t   out_speed_out;
  logic     out_calibrating;

  multiturn_encoder_rate_average #(
    .WINDOW_LEN (WINDOW_LEN),
    .TURN_BITS  (TURN_BITS)
  ) u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_encoder_position     (in_encoder_position),
    .in_speed_report         (in_speed_report),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_continuous_position (out_continuous_position),
    .out_angle_counts        (out_angle_counts),
    .out_average_rate        (out_average_rate),
    .out_speed_out           (out_speed_out),
    .out_calibrating         (out_calibrating)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block keeps.
  // ---------------------------------------------------------------------------
  cal_cnt_t cal_limit    = CAL_RESET;  // mirror of calib_reports
  cal_cnt_t reports_seen = '0;         // only counts calibration items
  pos_t     bias_pos     = '0;
  pos_t     last_pos     = '0;
  longint   turns        = 0;
  longint   inc_window[WINDOW_LEN];
  int       win_ptr      = 0;
  longint   inc_sum      = 0;

  report_result_t pending_results[$];  // expected items in arrival order
  report_result_t head;

  // Bench bookkeeping.
  int   fail_count = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   cal_items = 0;
  int   wrap_count = 0;
  int   cfg_writes = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  bit   steady_sender = 1'b0;
  pos_t last_sent_pos = '0;

  int          stall_left = 0;
  stall_mode_t stall_kind = STALL_NONE;

  initial begin
    for (int i = 0; i < WINDOW_LEN; i++) inc_window[i] = 0;
  end

  // Advances the predictor by one accepted item and returns its result.
  function automatic report_result_t predict_report(pos_t pos, speed_t spd);
    report_result_t r;
    longint diff;
    longint inc;
    longint cont;
    logic   cal_now;
    cal_now = (reports_seen < cal_limit);
    if (cal_now) begin
      // bias capture: turn count and window stay as they are
      bias_pos     = pos;
      last_pos     = pos;
      reports_seen = reports_seen + 1'b1;
      cal_items++;
    end else begin
      diff = longint'(pos) - longint'(last_pos);
      if (diff < -HALF_COUNTS) begin
        // crossed zero going forward
        if (turns < TURN_MAX) turns++;
        inc = diff + FULL_COUNTS;
        wrap_count++;
      end else if (diff > HALF_COUNTS) begin
        // crossed zero going backward
        if (turns > TURN_MIN) turns--;
        inc = diff - FULL_COUNTS;
        wrap_count++;
      end else begin
        inc = diff;
      end
      last_pos = pos;
      inc_sum += inc - inc_window[win_ptr];
      inc_window[win_ptr] = inc;
      win_ptr = (win_ptr + 1) % WINDOW_LEN;
    end
    cont       = longint'(pos) + turns * FULL_COUNTS;
    r.cont_pos = cont_t'(cont);
    r.angle    = cont_t'(cont - longint'(bias_pos));
    r.avg_rate = rate_t'(inc_sum / WINDOW_LEN);  // SV division truncates toward zero
    r.speed    = spd;
    r.cal      = cal_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Failure reporting and result checking.
  // ---------------------------------------------------------------------------
  function automatic void record_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTED) $display("ERROR: %s", msg);
  endfunction

  function automatic void compare_field(string name, logic signed [63:0] want_v,
                                        logic signed [63:0] got_v);
    if (got_v !== want_v)
      record_failure($sformatf("result %0d %s: expected %0d, got %0d",
                               results_seen, name, want_v, got_v));
  endfunction

  // Outputs are sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        record_failure($sformatf("unexpected result item: cont %0d angle %0d rate %0d",
                                 out_continuous_position, out_angle_counts,
                                 out_average_rate));
      end else begin
        head = pending_results.pop_front();
        compare_field("continuous_position", head.cont_pos, out_continuous_position);
        compare_field("angle_counts", head.angle, out_angle_counts);
        compare_field("average_rate", head.avg_rate, out_average_rate);
        compare_field("speed_out", head.speed, out_speed_out);
        compare_field("calibrating", head.cal, out_calibrating);
        results_seen++;
      end
    end
  end

  // Receiver stall pattern: segments of no stall, light, heavy and solid stall.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_kind)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
      default:     out_stall <= (stall_left < 12);  // solid block at segment end
    endcase
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected",
               cycle_count, pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Valid goes high at a falling edge and stays high across a
  // burst; it is lowered at a different falling edge for a gap or a drain.
  // ---------------------------------------------------------------------------
  task automatic send_report(input pos_t pos, input speed_t spd);
    int gap;
    if (burst_left == 0) begin
      if (!steady_sender) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid            <= 1'b1;
    in_encoder_position <= pos;
    in_speed_report     <= spd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    pending_results.push_back(predict_report(pos, spd));
    last_sent_pos = pos;
    items_sent++;
  endtask

  // Drops valid and waits until every expected item is back, plus the pipe depth.
  task automatic wait_drained();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // calib_reports is only written with the block idle.
  task automatic write_cal_limit(input cal_cnt_t value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cal_limit = value;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // calib_reports of zero right after reset: no bias capture, bias stays zero.
  // Also covers position and speed extremes and a wrap each way across zero.
  task automatic test_no_calibration();
    write_cal_limit(4'd0);
    send_report(13'd0, 16'sd0);
    send_report(13'd8191, 16'sd32767);    // big backward jump: one turn down
    send_report(13'd0, -16'sd32768);      // big forward jump: back up a turn
    send_report(13'd1, -16'sd1);
  endtask

  // Normal calibration: five items capture bias, then tracking resumes.
  task automatic test_calibration();
    write_cal_limit(4'd5);
    send_report(13'd100, 16'sd1234);
    send_report(13'd8000, -16'sd1234);
    send_report(13'd4000, 16'sd0);
    send_report(13'd1234, 16'sd16384);
    send_report(13'd7777, -16'sd16385);
    send_report(13'd7700, 16'sd100);      // first tracked item, bias is 7777
  endtask

  // Exactly half a turn is no wrap; one count more is.
  task automatic test_half_turn();
    send_report(13'd100, 16'sd200);       // wraps forward from 7700
    send_report(13'd4196, 16'sd300);      // +4096
    send_report(13'd100, -16'sd300);      // -4096
    send_report(13'd4197, 16'sd400);      // +4097
    send_report(13'd100, -16'sd400);      // -4097
  endtask

  // Lowering the limit below the count ends calibration at once; raising it
  // again resumes capture for the difference.
  task automatic test_limit_change();
    write_cal_limit(4'd2);
    send_report(13'd8191, 16'sd7);
    write_cal_limit(4'd7);
    send_report(13'd50, 16'sd8);          // calibrating
    send_report(13'd60, 16'sd9);          // calibrating
    send_report(13'd70, 16'sd10);         // tracking again
  endtask

  // Random rotation: segments of near-constant velocity with noise, exact and
  // near half-turn jumps, random positions and extremes.
  task automatic test_random_motion();
    int       phase;
    int       n;
    int       seg_left;
    int       velocity;
    int       stride;
    int       mode;
    cal_cnt_t setting;
    pos_t     pos;
    speed_t   spd;
    pos = last_sent_pos;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       setting = 4'd15;  // resumes capture for the rest of the count
        4:       setting = 4'd0;
        default: setting = cal_cnt_t'($urandom_range(0, 15));
      endcase
      write_cal_limit(setting);
      steady_sender = (phase == 3);  // a phase with no sender gaps
      seg_left = 0;
      velocity = 0;
      for (n = 0; n < 100; n++) begin
        // one hold-off until all results are back, mid phase
        if (phase == 2 && n == 50) wait_drained();
        if (seg_left == 0) begin
          if ($urandom_range(0, 1))
            velocity = int'($urandom_range(0, 600)) - 300;
          else
            velocity = int'($urandom_range(0, 8192)) - 4096;
          seg_left = $urandom_range(8, 24);
        end
        seg_left--;
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
          stride = velocity + int'($urandom_range(0, 64)) - 32;
          pos = pos_t'(int'(pos) + stride);
        end else if (mode < 82) begin
          stride = ($urandom_range(0, 1) ? HALF_COUNTS : -HALF_COUNTS)
                   + int'($urandom_range(0, 2)) - 1;
          pos = pos_t'(int'(pos) + stride);
        end else if (mode < 94) begin
          pos = pos_t'($urandom);
        end else begin
          pos = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
        end
        case ($urandom_range(0, 9))
          0:       spd = -16'sd32768;
          1:       spd = 16'sd32767;
          2:       spd = -16'sd1;
          default: spd = speed_t'($urandom);
        endcase
        send_report(pos, spd);
      end
    end
    steady_sender = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_no_calibration();
    test_calibration();
    test_half_turn();
    test_limit_change();
    test_random_motion();

    wait_drained();
    $display("covered %0d items (%0d bias capture, %0d turn wraps), %0d calib_reports writes",
             items_sent, cal_items, wrap_count, cfg_writes);
    $display("checked %0d result items, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mera_pkg.sv
rtl/core/mera_cell.sv
rtl/core/mera_mean.sv
rtl/core/multiturn_encoder_rate_average.sv
bench/tb_multiturn_encoder_rate_average.sv
